// ----- rtl/core/tlg_pkg.sv -----
// ---------------------------------------------------------------------------
// tlg_pkg
// Shared types, constants and helpers of the tremolo gain block.
// ---------------------------------------------------------------------------
package tlg_pkg;

    localparam int SAMPLE_W = 16;
    localparam int HP_W     = 20;
    localparam int SEL_W    = 2;
    localparam int PHASE_W  = 21;
    localparam int WAVE_W   = 32;
    localparam int NUM_W    = 33;
    localparam int PROD_W   = 47;
    localparam int CNT_W    = 6;

    localparam logic signed [34:0] Q_ONE       = 35'sd1073741824;
    localparam logic signed [34:0] SMOOTH_STEP = 35'sd21474836;
    localparam logic [NUM_W-1:0]   TWO_Q_ONE   = 33'h0_8000_0000;

    localparam logic [HP_W-1:0]  HP_RESET  = 20'd22050;

    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_WAVE_SEL    = 1'b1;

    localparam logic [SEL_W-1:0] WAVE_SQUARE   = 2'd0;
    localparam logic [SEL_W-1:0] WAVE_TRIANGLE = 2'd1;
    localparam logic [SEL_W-1:0] WAVE_PARABOLA = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_TRI,
        ST_PAR_START,
        ST_DIV_PAR,
        ST_MUL,
        ST_OUT
    } tlg_state_t;

    // saturate a wide sum to plus or minus one in q2.30
    function automatic logic signed [WAVE_W-1:0] clamp_q(input logic signed [34:0] v);
        logic signed [34:0] r;
        begin
            if (v > Q_ONE)
            begin
                r = Q_ONE;
            end
            else if (v < -Q_ONE)
            begin
                r = -Q_ONE;
            end
            else
            begin
                r = v;
            end
            clamp_q = r[WAVE_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/core/tlg_div.sv -----
// ---------------------------------------------------------------------------
// tlg_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ---------------------------------------------------------------------------
module tlg_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tlg_pkg::NUM_W-1:0]  dividend,
    input  logic [tlg_pkg::HP_W-1:0]   divisor,
    output logic                       done,
    output logic [tlg_pkg::NUM_W-1:0]  quotient
);
    import tlg_pkg::*;

    logic                busy_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [NUM_W-1:0]    quot_reg;
    logic [HP_W-1:0]     rem_reg;
    logic [HP_W-1:0]     den_reg;

    logic [HP_W:0]       rem_sh;
    logic [HP_W+1:0]     diff;
    logic [HP_W-1:0]     rem_next;
    logic                qbit;

    always_comb
    begin
        rem_sh = {rem_reg, quot_reg[NUM_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, den_reg};
        qbit   = ~diff[HP_W+1];
        rem_next = qbit ? diff[HP_W-1:0] : rem_sh[HP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            quot_reg <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
            quot_reg <= dividend;
            rem_reg  <= '0;
            den_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                quot_reg <= {quot_reg[NUM_W-2:0], qbit};
                rem_reg  <= rem_next;
            end
            else
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = quot_reg;

endmodule

// ----- rtl/core/tremolo_lfo_gain.sv -----
// ---------------------------------------------------------------------------
// tremolo_lfo_gain
// Tremolo: audio samples scaled by a slow square, triangle or parabola gain.
// ---------------------------------------------------------------------------
// usage
//   s_axis carries one signed 16-bit sample per item, m_axis returns the
//   sample scaled by (w + 1) / 2, truncated toward zero, one item per input.
//   cfg_we / cfg_index / cfg_data write half_period_samples (index 0) and
//   wave_select (index 1); write only while the block is idle.
// sequence
//   an accepted item passes twice through the shared one-bit-per-cycle
//   divider (full step of the triangle, then the parabola step), with a
//   start state for the second pass between them, then the multiply and
//   output states and back to idle. s_axis_tready is high only while the
//   sequencer is idle, so a new item is taken only after the last one has
//   left the output state.
// reset
//   registers return to half period 22050 and parabola wave, the phase
//   counter clears and the waves restart at square +1, triangle -1,
//   parabola 0.
// stall
//   the output register holds a result until m_axis_tready; the next item
//   may be accepted meanwhile and waits in its final stage for the slot.
// ---------------------------------------------------------------------------
module tremolo_lfo_gain (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,   // [15:0] sample_in
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [15:0]                    m_axis_tdata,   // [15:0] sample_out
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [tlg_pkg::HP_W-1:0]       cfg_data
);
    import tlg_pkg::*;

    tlg_state_t                state_reg, state_next;

    logic [HP_W-1:0]           hp_reg;
    logic [SEL_W-1:0]          wsel_reg;
    logic [PHASE_W-1:0]        phase_reg, phase_next;
    logic                      sqpos_reg, sqpos_next;
    logic signed [WAVE_W-1:0]  smooth_reg, smooth_next;
    logic signed [WAVE_W-1:0]  tri_reg, tri_next;
    logic signed [WAVE_W-1:0]  par_reg, par_next;
    logic signed [SAMPLE_W-1:0] samp_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [SAMPLE_W-1:0]       out_reg;
    logic                      out_valid_reg;

    logic                      in_acc;
    logic                      out_load;
    logic [HP_W-1:0]           hp_eff;
    logic                      flip;
    logic signed [34:0]        sq_wide;
    logic signed [34:0]        smooth_sum;
    logic signed [34:0]        q_signed;
    logic signed [34:0]        tri_sum;
    logic signed [34:0]        par_sum;
    logic [WAVE_W-2:0]         tri_abs;
    logic signed [WAVE_W-1:0]  wave;
    logic signed [WAVE_W:0]    wave_off;
    logic [WAVE_W-1:0]         gain;
    logic [SAMPLE_W-1:0]       samp_abs;
    logic [47:0]               prod_full;
    logic [SAMPLE_W-1:0]       mag;

    logic                      div_start;
    logic [NUM_W-1:0]          div_dividend;
    logic                      div_done;
    logic [NUM_W-1:0]          div_quot;

    tlg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (hp_eff),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign hp_eff        = (hp_reg == '0) ? HP_W'(1) : hp_reg;
    assign flip          = phase_reg > {1'b0, hp_eff};
    assign tri_abs       = tri_reg[WAVE_W-1] ? (WAVE_W-1)'(-tri_reg) : tri_reg[WAVE_W-2:0];
    assign div_start     = in_acc || (state_reg == ST_PAR_START);
    assign div_dividend  = (state_reg == ST_IDLE) ? TWO_Q_ONE : {tri_abs, 2'b00};
    assign q_signed      = $signed({2'b00, div_quot});
    assign mag           = prod_reg[PROD_W-1:PROD_W-SAMPLE_W];

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        sqpos_next  = sqpos_reg;
        smooth_next = smooth_reg;
        tri_next    = tri_reg;
        par_next    = par_reg;
        out_load    = 1'b0;
        sq_wide     = '0;
        smooth_sum  = '0;
        tri_sum     = '0;
        par_sum     = '0;
        wave        = smooth_reg;
        wave_off    = '0;
        gain        = '0;
        samp_abs    = '0;
        prod_full   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    sqpos_next = flip ? ~sqpos_reg : sqpos_reg;
                    phase_next = (flip ? PHASE_W'(0) : phase_reg) + 1'b1;
                    sq_wide    = sqpos_next ? Q_ONE : -Q_ONE;
                    if (sq_wide > 35'(smooth_reg))
                    begin
                        smooth_sum = 35'(smooth_reg) + SMOOTH_STEP;
                    end
                    else if (sq_wide < 35'(smooth_reg))
                    begin
                        smooth_sum = 35'(smooth_reg) - SMOOTH_STEP;
                    end
                    else
                    begin
                        smooth_sum = 35'(smooth_reg);
                    end
                    smooth_next = clamp_q(smooth_sum);
                    state_next  = ST_DIV_TRI;
                end
            end
            ST_DIV_TRI:
            begin
                if (div_done)
                begin
                    tri_sum    = 35'(tri_reg) + (sqpos_reg ? q_signed : -q_signed);
                    tri_next   = clamp_q(tri_sum);
                    state_next = ST_PAR_START;
                end
            end
            ST_PAR_START:
            begin
                state_next = ST_DIV_PAR;
            end
            ST_DIV_PAR:
            begin
                if (div_done)
                begin
                    par_sum    = 35'(par_reg) + (tri_reg[WAVE_W-1] ? -q_signed : q_signed);
                    par_next   = clamp_q(par_sum);
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                case (wsel_reg)
                    WAVE_TRIANGLE: wave = tri_reg;
                    WAVE_PARABOLA: wave = par_reg;
                    default:       wave = smooth_reg;
                endcase
                wave_off   = 33'(wave) + Q_ONE[WAVE_W:0];
                gain       = wave_off[WAVE_W-1:0];
                samp_abs   = samp_reg[SAMPLE_W-1] ? SAMPLE_W'(-samp_reg) : samp_reg;
                prod_full  = 48'(samp_abs) * 48'(gain);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hp_reg        <= HP_RESET;
            wsel_reg      <= WAVE_PARABOLA;
            phase_reg     <= '0;
            sqpos_reg     <= 1'b1;
            smooth_reg    <= Q_ONE[WAVE_W-1:0];
            tri_reg       <= -Q_ONE[WAVE_W-1:0];
            par_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            sqpos_reg  <= sqpos_next;
            smooth_reg <= smooth_next;
            tri_reg    <= tri_next;
            par_reg    <= par_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HALF_PERIOD: hp_reg   <= cfg_data;
                    CFG_WAVE_SEL:    wsel_reg <= cfg_data[SEL_W-1:0];
                    default:         hp_reg   <= hp_reg;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            samp_reg <= $signed(s_axis_tdata);
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod_full[PROD_W-1:0];
        end
        if (out_load)
        begin
            out_reg <= samp_reg[SAMPLE_W-1] ? SAMPLE_W'(-mag) : mag;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    // an accepted item always starts with the triangle division
    a_acc_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == ST_DIV_TRI))
        else $error("accepted item did not enter the triangle division");

    // divider results only show up while the sequencer waits for them
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_TRI || state_reg == ST_DIV_PAR))
        else $error("divider finished outside a division state");

    // the waves stay saturated to plus or minus one
    a_tri_range: assert property (@(posedge clk) disable iff (!rst_n)
        (35'(tri_reg) <= Q_ONE) && (35'(tri_reg) >= -Q_ONE))
        else $error("triangle left the unit range");

    a_par_range: assert property (@(posedge clk) disable iff (!rst_n)
        (35'(par_reg) <= Q_ONE) && (35'(par_reg) >= -Q_ONE))
        else $error("parabola left the unit range");

    // a waiting result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("result register overwritten while stalled");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the tremolo gain block.
// A directed table walks reset values, pass-through on the square wave,
// full-scale samples, the zero half period and the unused wave selector.
// Random phases follow, each with fresh half period and wave settings.
// Output items are checked against table values or a model of the three waves.
// Both stream sides idle at random, and the run ends on a drain.
// ---------------------------------------------------------------------------
module tb;

    import tlg_pkg::*;

    localparam longint     Q_UNIT      = 64'sd1073741824;
    localparam longint     RAMP_STEP   = 64'sd21474836;
    localparam int         N_ITEMS     = 1550;
    localparam int         IDLE_LIMIT  = 2000;
    localparam int         END_WAIT    = 100;
    localparam int         N_DIR       = 25;

    typedef struct packed {
        logic        is_cfg;
        logic        idx;
        logic [19:0] val;
        logic [15:0] smp;
        logic        typed;
        logic [15:0] want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'h0000;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [19:0] cfg_data = 20'h00000;

    // model state
    logic [19:0] hp_reg;
    logic [1:0]  sel_reg;
    logic [20:0] lfo_phase;
    bit          sq_pos;
    longint      sq_smooth;
    longint      tri_lvl;
    longint      par_lvl;

    logic [15:0] sample_exp_q [$];
    bit          calm;
    bit          tx_busy;
    int          mismatch_cnt;
    int          rx_count;
    int          idle_cycles;
    int          rdy_hold;

    always #4 clk = ~clk;

    tremolo_lfo_gain u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    function automatic longint sat_unit(input longint v);
        if (v > Q_UNIT)
        begin
            return Q_UNIT;
        end
        if (v < -Q_UNIT)
        begin
            return -Q_UNIT;
        end
        return v;
    endfunction

    function automatic logic [15:0] tremolo_predict(input logic [15:0] smp);
        longint h;
        longint sq;
        longint w;
        longint s;
        longint res;
        h = (hp_reg == 20'd0) ? 64'sd1 : longint'(hp_reg);
        s = longint'($signed(smp));
        if (longint'(lfo_phase) > h)
        begin
            sq_pos = !sq_pos;
            lfo_phase = '0;
        end
        sq = sq_pos ? Q_UNIT : -Q_UNIT;
        if (sq > sq_smooth)
        begin
            sq_smooth = sq_smooth + RAMP_STEP;
        end
        else if (sq < sq_smooth)
        begin
            sq_smooth = sq_smooth - RAMP_STEP;
        end
        sq_smooth = sat_unit(sq_smooth);
        tri_lvl = sat_unit(tri_lvl + (2 * sq) / h);
        par_lvl = sat_unit(par_lvl + (tri_lvl * 4) / h);
        if (sel_reg == WAVE_TRIANGLE)
        begin
            w = tri_lvl;
        end
        else if (sel_reg == WAVE_PARABOLA)
        begin
            w = par_lvl;
        end
        else
        begin
            w = sq_smooth;
        end
        res = (s * (w + Q_UNIT)) / (2 * Q_UNIT);
        lfo_phase = lfo_phase + 21'd1;
        return res[15:0];
    endfunction

    function automatic dir_row_t cfg_row(input logic idx, input logic [19:0] val);
        return '{1'b1, idx, val, 16'h0000, 1'b0, 16'h0000};
    endfunction

    function automatic dir_row_t smp_row(input logic [15:0] smp, input logic typed,
                                         input logic [15:0] want);
        return '{1'b0, 1'b0, 20'h00000, smp, typed, want};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 95)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] rand_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return 16'($urandom);
        end
        if (r < 85)
        begin
            case ($urandom_range(0, 4))
                0: return 16'h7fff;
                1: return 16'h8000;
                2: return 16'h0000;
                3: return 16'hffff;
                default: return 16'h0001;
            endcase
        end
        return 16'($urandom_range(0, 15) - 8);
    endfunction

    function automatic logic [19:0] rand_half_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            return 20'($urandom_range(1, 40));
        end
        if (r < 70)
        begin
            return 20'($urandom_range(41, 3000));
        end
        if (r < 78)
        begin
            return 20'd0;
        end
        if (r < 86)
        begin
            return 20'hfffff;
        end
        if (r < 93)
        begin
            return 20'($urandom);
        end
        return HP_RESET;
    endfunction

    task automatic lower_sender();
        if (tx_busy)
        begin
            s_axis_tvalid <= 1'b0;
            tx_busy = 1'b0;
        end
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            lower_sender();
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        lower_sender();
        while (sample_exp_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [19:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_HALF_PERIOD)
        begin
            hp_reg = val;
        end
        else
        begin
            sel_reg = val[1:0];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(input logic [15:0] smp, input logic typed,
                               input logic [15:0] want);
        logic [15:0] pred;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        tx_busy = 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pred = tremolo_predict(smp);
        sample_exp_q.push_back(typed ? want : pred);
    endtask

    // receiver with random stalls
    always @(posedge clk)
    begin
        if (rdy_hold > 0)
        begin
            rdy_hold <= rdy_hold - 1;
        end
        else if (calm)
        begin
            m_axis_tready <= 1'b1;
            rdy_hold <= $urandom_range(0, 20);
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    m_axis_tready <= 1'b1;
                    rdy_hold <= $urandom_range(0, 10);
                end
                6, 7, 8:
                begin
                    m_axis_tready <= 1'b0;
                    rdy_hold <= $urandom_range(1, 4);
                end
                default:
                begin
                    m_axis_tready <= 1'b0;
                    rdy_hold <= $urandom_range(20, 80);
                end
            endcase
        end
    end

    // output checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (sample_exp_q.size() == 0)
            begin
                if (mismatch_cnt < 10)
                begin
                    $display("unexpected item %0d: got %0d", rx_count, $signed(m_axis_tdata));
                end
                mismatch_cnt++;
            end
            else
            begin
                if (m_axis_tdata !== sample_exp_q[0])
                begin
                    if (mismatch_cnt < 10)
                    begin
                        $display("sample_out mismatch on item %0d: expected %0d, got %0d",
                                 rx_count, $signed(sample_exp_q[0]), $signed(m_axis_tdata));
                    end
                    mismatch_cnt++;
                end
                void'(sample_exp_q.pop_front());
            end
            rx_count++;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        dir_row_t    dir_tab [N_DIR];
        dir_row_t    row;
        int          n_sent;
        int          n_phase;
        logic [19:0] hp_val;
        logic [19:0] sel_val;

        dir_tab = '{
            smp_row(16'h0000, 1'b1, 16'h0000),
            smp_row(16'h7fff, 1'b0, 16'h0000),
            smp_row(16'h8000, 1'b0, 16'h0000),
            cfg_row(CFG_WAVE_SEL, 20'(WAVE_SQUARE)),
            // square still at plus one: gain of one
            smp_row(16'h7fff, 1'b1, 16'h7fff),
            smp_row(16'h8000, 1'b1, 16'h8000),
            smp_row(16'h0001, 1'b1, 16'h0001),
            smp_row(16'hffff, 1'b1, 16'hffff),
            // zero half period acts as one
            cfg_row(CFG_HALF_PERIOD, 20'd0),
            smp_row(16'h7fff, 1'b0, 16'h0000),
            smp_row(16'h8000, 1'b0, 16'h0000),
            smp_row(16'h5555, 1'b0, 16'h0000),
            smp_row(16'haaaa, 1'b0, 16'h0000),
            // data masked down to the unused selector
            cfg_row(CFG_WAVE_SEL, 20'hfffff),
            smp_row(16'h7fff, 1'b0, 16'h0000),
            smp_row(16'h8000, 1'b0, 16'h0000),
            cfg_row(CFG_WAVE_SEL, 20'(WAVE_TRIANGLE)),
            cfg_row(CFG_HALF_PERIOD, 20'd1),
            smp_row(16'h7fff, 1'b0, 16'h0000),
            smp_row(16'h8000, 1'b0, 16'h0000),
            smp_row(16'h1234, 1'b0, 16'h0000),
            cfg_row(CFG_HALF_PERIOD, 20'hfffff),
            cfg_row(CFG_WAVE_SEL, 20'(WAVE_PARABOLA)),
            smp_row(16'h7fff, 1'b0, 16'h0000),
            smp_row(16'h8000, 1'b0, 16'h0000)
        };

        hp_reg       = HP_RESET;
        sel_reg      = WAVE_PARABOLA;
        lfo_phase    = '0;
        sq_pos       = 1'b1;
        sq_smooth    = Q_UNIT;
        tri_lvl      = -Q_UNIT;
        par_lvl      = 0;
        calm         = 1'b0;
        tx_busy      = 1'b0;
        mismatch_cnt = 0;
        rx_count     = 0;
        idle_cycles  = 0;
        rdy_hold     = 0;
        n_sent       = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < N_DIR; i++)
        begin
            row = dir_tab[i];
            if (row.is_cfg)
            begin
                drain_results();
                write_reg(row.idx, row.val);
            end
            else
            begin
                send_sample(row.smp, row.typed, row.want);
                n_sent++;
                idle_gap(pick_gap());
            end
        end

        // random phases
        while (n_sent < N_ITEMS)
        begin
            drain_results();
            hp_val  = rand_half_period();
            sel_val = 20'($urandom_range(0, 3));
            if ($urandom_range(0, 1))
            begin
                sel_val = sel_val | (20'($urandom) & 20'hffffc);
            end
            if ($urandom_range(0, 1))
            begin
                write_reg(CFG_HALF_PERIOD, hp_val);
                write_reg(CFG_WAVE_SEL, sel_val);
            end
            else
            begin
                write_reg(CFG_WAVE_SEL, sel_val);
                write_reg(CFG_HALF_PERIOD, hp_val);
            end
            calm    = ($urandom_range(0, 3) == 0);
            n_phase = $urandom_range(40, 150);
            for (int k = 0; k < n_phase; k++)
            begin
                send_sample(rand_sample(), 1'b0, 16'h0000);
                n_sent++;
                if ($urandom_range(0, 99) == 0)
                begin
                    drain_results();
                end
                else
                begin
                    idle_gap(pick_gap());
                end
            end
        end

        drain_results();
        calm = 1'b0;
        repeat (END_WAIT) @(posedge clk);

        if (mismatch_cnt == 0 && sample_exp_q.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/tlg_pkg.sv
rtl/core/tlg_div.sv
rtl/core/tremolo_lfo_gain.sv
tb/tb.sv
